>>> design/usbpd_pkg.sv
// ----------------------------------------------------------------------------
// usbpd_pkg
// Shared types and codes of the USB PD protocol layer (header level).
// ----------------------------------------------------------------------------
package usbpd_pkg;

  // command codes on the input channel
  localparam logic [2:0] CMD_RX_FRAME   = 3'd0;
  localparam logic [2:0] CMD_QUEUE_TX   = 3'd1;
  localparam logic [2:0] CMD_FLUSH_TX   = 3'd2;
  localparam logic [2:0] CMD_PROT_RESET = 3'd3;
  localparam logic [2:0] CMD_HARD_RESET = 3'd4;
  localparam logic [2:0] CMD_ATTACH     = 3'd5;

  // action codes on the result channel
  localparam logic [2:0] ACT_SEND      = 3'd0;
  localparam logic [2:0] ACT_DELIVER   = 3'd1;
  localparam logic [2:0] ACT_FLUSH_PHY = 3'd2;
  localparam logic [2:0] ACT_DROP_DUP  = 3'd3;
  localparam logic [2:0] ACT_DROP_GCRC = 3'd4;
  localparam logic [2:0] ACT_DONE      = 3'd5;

  // configuration register indexes
  localparam logic REG_DATA_ROLE  = 1'b0;
  localparam logic REG_POWER_ROLE = 1'b1;

  // header fields
  localparam logic [4:0] TYPE_GOODCRC    = 5'h01;
  localparam logic [4:0] TYPE_SOFT_RESET = 5'h0D;
  localparam logic [4:0] HW_ACK_MAX_TYPE = 5'h0D;
  localparam logic [1:0] REV_2_0         = 2'd1;
  localparam logic [1:0] REV_3_0         = 2'd2;
  localparam logic [2:0] SOP_PLAIN       = 3'd0;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] header;
    logic [2:0]  sop_kind;
    logic [1:0]  rev;
    logic [31:0] total;
    logic        last;
  } result_t;

endpackage

>>> design/usbpd_if.sv
// ----------------------------------------------------------------------------
// usbpd_in_if / usbpd_out_if
// Valid/ready channels of the PD protocol layer: command beats in, results out.
// ----------------------------------------------------------------------------
interface usbpd_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [15:0] msg_header;
  logic [2:0]  sop_kind;

  modport source (output valid, command, msg_header, sop_kind, input ready);
  modport sink   (input valid, command, msg_header, sop_kind, output ready);
endinterface

interface usbpd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [15:0] out_header;
  logic [2:0]  out_sop_kind;
  logic [1:0]  our_spec_rev;
  logic [31:0] delivered_total;
  logic        last;

  modport source (output valid, action, out_header, out_sop_kind, our_spec_rev,
                  delivered_total, last, input ready);
  modport sink   (input valid, action, out_header, out_sop_kind, our_spec_rev,
                  delivered_total, last, output ready);
endinterface

>>> design/usb_pd_protocol_layer.sv
// ----------------------------------------------------------------------------
// usb_pd_protocol_layer
// USB PD protocol layer on message headers: GoodCRC, dedup, MessageID, tx slot.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : command beats (rx frame, queue tx, flush tx, protocol reset,
//            hard reset, attach) with a 16-bit header and SOP kind.
//   out_ch : one or two result beats per command; last marks the final one.
//   cfg_*  : data role and power role bits, written while the block is idle.
// Output: the first result of a command is valid the cycle after its beat
//   is accepted. A command that makes two results (software GoodCRC before a
//   delivery or duplicate drop, or a queued frame sent ahead of a new one)
//   parks the second in the one-entry holding register behind the single
//   output register.
// in_ch.ready is high when the holding register is empty and the output
//   register is empty or being taken this cycle.
// Reset: counters clear, the tx slot empties, revision returns to R3.0, role
//   bits clear, no result pending.
// A stalled receiver holds the current result; at most one more result waits
//   in the holding register, and input is then held off.
// ----------------------------------------------------------------------------
module usb_pd_protocol_layer
  import usbpd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  usbpd_in_if.sink      in_ch,
  usbpd_out_if.source   out_ch,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic          cfg_wdata
);

  // layer state
  logic        dfp_r, src_r;
  logic [2:0]  next_tx_id_r, next_tx_id_nxt;
  logic [2:0]  last_rx_id_r, last_rx_id_nxt;
  logic        known_r, known_nxt;
  logic        slot_full_r, slot_full_nxt;
  logic [15:0] slot_hdr_r;
  logic [2:0]  slot_sop_r;
  logic [1:0]  rev_r, rev_nxt;
  logic [31:0] count_r, count_nxt;

  // result buffering
  result_t     out_r, pend_r;
  logic        out_v_r, pend_v_r;

  logic        accept, out_take;
  result_t     pre_res, fin_res;
  logic        pre_en;

  // decoded header fields
  logic [15:0] hdr;
  logic [4:0]  frame_type;
  logic [2:0]  ndo, rx_id;
  logic        is_sop, ack_en, gcrc_drop, soft_rst, known_eff, dup;
  logic [1:0]  peer_rev, rev_obs;
  logic [15:0] ack_hdr, stamped_hdr;

  assign out_take    = out_v_r && out_ch.ready;
  assign in_ch.ready = !pend_v_r && (!out_v_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  assign hdr        = in_ch.msg_header;
  assign frame_type = hdr[4:0];
  assign ndo        = hdr[14:12];
  assign rx_id      = hdr[11:9];
  assign is_sop     = (in_ch.sop_kind == SOP_PLAIN);
  assign ack_en     = is_sop && !hdr[15] && (frame_type > HW_ACK_MAX_TYPE);
  assign gcrc_drop  = (frame_type == TYPE_GOODCRC) && (ndo == 3'd0);
  assign soft_rst   = is_sop && (frame_type == TYPE_SOFT_RESET) && (ndo == 3'd0);
  assign known_eff  = known_r && !soft_rst;
  assign dup        = is_sop && known_eff && (last_rx_id_r == rx_id);
  // partner revision 00 is taken as R2.0; we only ever step down
  assign peer_rev   = (hdr[7:6] == 2'd0) ? REV_2_0 : hdr[7:6];
  assign rev_obs    = (is_sop && (peer_rev < rev_r)) ? peer_rev : rev_r;

  assign ack_hdr     = {4'd0, rx_id, src_r, REV_2_0, dfp_r, TYPE_GOODCRC};
  assign stamped_hdr = {slot_hdr_r[15:12], next_tx_id_r, slot_hdr_r[8:0]};

  always_comb begin
    next_tx_id_nxt = next_tx_id_r;
    last_rx_id_nxt = last_rx_id_r;
    known_nxt      = known_r;
    slot_full_nxt  = slot_full_r;
    rev_nxt        = rev_r;
    count_nxt      = count_r;
    pre_en         = 1'b0;
    pre_res        = '{ACT_SEND, 16'd0, SOP_PLAIN, rev_r, count_r, 1'b0};
    fin_res        = '{ACT_DONE, 16'd0, SOP_PLAIN, rev_r, count_r, 1'b1};
    case (in_ch.command)
      CMD_RX_FRAME: begin
        pre_en         = ack_en;
        pre_res.header = ack_hdr;
        if (gcrc_drop) begin
          fin_res.action = ACT_DROP_GCRC;
        end else begin
          rev_nxt     = rev_obs;
          fin_res.rev = rev_obs;
          if (soft_rst) begin
            next_tx_id_nxt = 3'd0;
          end
          if (dup) begin
            known_nxt      = known_eff;
            fin_res.action = ACT_DROP_DUP;
          end else begin
            if (is_sop) begin
              last_rx_id_nxt = rx_id;
              known_nxt      = 1'b1;
            end
            count_nxt = count_r + 32'd1;
            fin_res   = '{ACT_DELIVER, hdr, in_ch.sop_kind, rev_obs, count_nxt, 1'b1};
          end
        end
      end
      CMD_QUEUE_TX: begin
        pre_en           = slot_full_r;
        pre_res.header   = stamped_hdr;
        pre_res.sop_kind = slot_sop_r;
        if (slot_full_r) begin
          next_tx_id_nxt = next_tx_id_r + 3'd1;
        end
        slot_full_nxt = 1'b1;
      end
      CMD_FLUSH_TX: begin
        if (slot_full_r) begin
          next_tx_id_nxt = next_tx_id_r + 3'd1;
          slot_full_nxt  = 1'b0;
          fin_res        = '{ACT_SEND, stamped_hdr, slot_sop_r, rev_r, count_r, 1'b1};
        end
      end
      CMD_PROT_RESET, CMD_HARD_RESET: begin
        next_tx_id_nxt = 3'd0;
        last_rx_id_nxt = 3'd0;
        known_nxt      = 1'b0;
        slot_full_nxt  = 1'b0;
        count_nxt      = 32'd0;
        fin_res.total  = 32'd0;
        if (in_ch.command == CMD_HARD_RESET) begin
          fin_res.action = ACT_FLUSH_PHY;
        end
      end
      CMD_ATTACH: begin
        rev_nxt     = REV_3_0;
        fin_res.rev = REV_3_0;
      end
      default: begin
      end
    endcase
  end

  // tx slot payload, no reset
  always_ff @(posedge clk) begin
    if (accept && (in_ch.command == CMD_QUEUE_TX)) begin
      slot_hdr_r <= hdr;
      slot_sop_r <= in_ch.sop_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dfp_r        <= 1'b0;
      src_r        <= 1'b0;
      next_tx_id_r <= 3'd0;
      last_rx_id_r <= 3'd0;
      known_r      <= 1'b0;
      slot_full_r  <= 1'b0;
      rev_r        <= REV_3_0;
      count_r      <= 32'd0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_DATA_ROLE) begin
          dfp_r <= cfg_wdata;
        end else begin
          src_r <= cfg_wdata;
        end
      end
      if (accept) begin
        next_tx_id_r <= next_tx_id_nxt;
        last_rx_id_r <= last_rx_id_nxt;
        known_r      <= known_nxt;
        slot_full_r  <= slot_full_nxt;
        rev_r        <= rev_nxt;
        count_r      <= count_nxt;
      end
    end
  end

  // output register plus one holding entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else if (accept) begin
      out_v_r  <= 1'b1;
      pend_v_r <= pre_en;
    end else if (pend_v_r && (out_take || !out_v_r)) begin
      out_v_r  <= 1'b1;
      pend_v_r <= 1'b0;
    end else if (out_take) begin
      out_v_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r  <= pre_en ? pre_res : fin_res;
      pend_r <= fin_res;
    end else if (pend_v_r && (out_take || !out_v_r)) begin
      out_r  <= pend_r;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.action          = out_r.action;
  assign out_ch.out_header      = out_r.header;
  assign out_ch.out_sop_kind    = out_r.sop_kind;
  assign out_ch.our_spec_rev    = out_r.rev;
  assign out_ch.delivered_total = out_r.total;
  assign out_ch.last            = out_r.last;

endmodule

>>> tb/usb_pd_protocol_layer_tb.sv
// ----------------------------------------------------------------------------
// usb_pd_protocol_layer_tb
// Self-checking bench for the PD protocol layer. Command beats (rx frames,
// tx queue/flush, resets, attach) are driven with random gaps. A local
// model of the layer computes the result beats each command should produce.
// Every accepted result beat is checked field by field, in order, against
// the oldest one still outstanding. Role bits change between phases.
// ----------------------------------------------------------------------------
module usb_pd_protocol_layer_tb;
  import usbpd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          SETTLE_CYCLES  = 4;
  localparam logic [2:0]  CMD_UNUSED_6   = 3'd6;
  localparam logic [2:0]  CMD_UNUSED_7   = 3'd7;
  localparam logic [1:0]  REV_RESERVED   = 2'd3;
  localparam logic [1:0]  REV_1_0        = 2'd0;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic cfg_wdata;

  usbpd_in_if  in_ch ();
  usbpd_out_if out_ch ();

  usb_pd_protocol_layer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // layer model state
  logic        role_dfp;
  logic        role_src;
  logic [2:0]  tx_msg_id;
  logic [2:0]  rx_msg_id;
  logic        rx_id_valid;
  logic        slot_full;
  logic [15:0] slot_hdr;
  logic [2:0]  slot_sop;
  logic [1:0]  cur_rev;
  logic [31:0] delivered;

  result_t     expected_beats[$];
  int          n_mismatch;
  int          idle_cycles;
  bit          steady;     // no gaps on either side while set
  bit          hold_req;   // asks the receiver for one long hold-off
  logic [2:0]  partner_id;
  logic [2:0]  prev_partner_id;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- model
  function automatic result_t beat_of(logic [2:0] act, logic [15:0] hdr, logic [2:0] sop);
    result_t b;
    b.action   = act;
    b.header   = hdr;
    b.sop_kind = sop;
    b.rev      = cur_rev;
    b.total    = delivered;
    b.last     = 1'b0;
    return b;
  endfunction

  function automatic result_t send_slot_beat();
    logic [15:0] stamped;
    result_t     b;
    stamped       = slot_hdr;
    stamped[11:9] = tx_msg_id;
    slot_full     = 1'b0;
    tx_msg_id     = tx_msg_id + 3'd1;
    b = beat_of(ACT_SEND, stamped, slot_sop);
    return b;
  endfunction

  function automatic void clear_layer();
    tx_msg_id   = '0;
    rx_msg_id   = '0;
    rx_id_valid = 1'b0;
    slot_full   = 1'b0;
    delivered   = '0;
  endfunction

  function automatic void predict_command(logic [2:0] c, logic [15:0] h, logic [2:0] s);
    result_t     b[2];
    int          n;
    logic [4:0]  typ;
    logic [2:0]  ndo;
    logic [2:0]  mid;
    logic [1:0]  peer;
    logic [15:0] ack;
    bit          dup;
    n   = 0;
    typ = h[4:0];
    ndo = h[14:12];
    mid = h[11:9];
    case (c)
      CMD_RX_FRAME: begin
        if (s == SOP_PLAIN && !h[15] && typ > HW_ACK_MAX_TYPE) begin
          ack  = {4'b0000, mid, role_src, REV_2_0, role_dfp, TYPE_GOODCRC};
          b[n] = beat_of(ACT_SEND, ack, SOP_PLAIN);
          n++;
        end
        if (typ == TYPE_GOODCRC && ndo == 3'd0) begin
          b[n] = beat_of(ACT_DROP_GCRC, '0, '0);
        end else begin
          dup = 1'b0;
          if (s == SOP_PLAIN) begin
            peer = h[7:6];
            if (peer == REV_1_0) peer = REV_2_0;
            if (peer < cur_rev) cur_rev = peer;
            if (typ == TYPE_SOFT_RESET && ndo == 3'd0) begin
              tx_msg_id   = '0;
              rx_id_valid = 1'b0;
            end
            if (rx_id_valid && rx_msg_id == mid) begin
              dup = 1'b1;
            end else begin
              rx_msg_id   = mid;
              rx_id_valid = 1'b1;
            end
          end
          if (dup) begin
            b[n] = beat_of(ACT_DROP_DUP, '0, '0);
          end else begin
            delivered = delivered + 32'd1;
            b[n] = beat_of(ACT_DELIVER, h, s);
          end
        end
        n++;
      end
      CMD_QUEUE_TX: begin
        if (slot_full) begin
          b[n] = send_slot_beat();
          n++;
        end
        slot_hdr  = h;
        slot_sop  = s;
        slot_full = 1'b1;
        b[n] = beat_of(ACT_DONE, '0, '0);
        n++;
      end
      CMD_FLUSH_TX: begin
        if (slot_full) b[n] = send_slot_beat();
        else b[n] = beat_of(ACT_DONE, '0, '0);
        n++;
      end
      CMD_PROT_RESET: begin
        clear_layer();
        b[n] = beat_of(ACT_DONE, '0, '0);
        n++;
      end
      CMD_HARD_RESET: begin
        clear_layer();
        b[n] = beat_of(ACT_FLUSH_PHY, '0, '0);
        n++;
      end
      CMD_ATTACH: begin
        cur_rev = REV_3_0;
        b[n] = beat_of(ACT_DONE, '0, '0);
        n++;
      end
      default: begin
        b[n] = beat_of(ACT_DONE, '0, '0);
        n++;
      end
    endcase
    b[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_beats.push_back(b[i]);
  endfunction

  // ---------------------------------------------------------------- helpers
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pd_header(bit ext, logic [2:0] ndo, logic [2:0] id,
                                            bit prole, logic [1:0] rev, bit drole,
                                            logic [4:0] typ);
    return {ext, ndo, id, prole, rev, drole, typ};
  endfunction

  function automatic logic [1:0] pick_rev();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return REV_3_0;
    if (r < 75) return REV_2_0;
    if (r < 90) return REV_1_0;
    return REV_RESERVED;
  endfunction

  function automatic logic [4:0] pick_type();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return TYPE_GOODCRC;
    if (r < 25) return TYPE_SOFT_RESET;
    if (r < 55) return 5'($urandom_range(0, 13));
    return 5'($urandom_range(14, 31));
  endfunction

  // one command beat; valid stays high afterwards unless the next call idles
  task automatic send_command(input logic [2:0] c, input logic [15:0] h,
                              input logic [2:0] s);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= c;
    in_ch.msg_header <= h;
    in_ch.sop_kind   <= s;
    do @(posedge clk); while (!in_ch.ready);
    predict_command(c, h, s);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both role registers, one write per cycle; called only when idle
  task automatic write_roles(input logic dfp, input logic src);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_DATA_ROLE;
    cfg_wdata <= dfp;
    @(posedge clk);
    cfg_index <= REG_POWER_ROLE;
    cfg_wdata <= src;
    @(posedge clk);
    cfg_we    <= 1'b0;
    role_dfp = dfp;
    role_src = src;
  endtask

  // partner-like SOP traffic with running MessageIDs, plus noise
  task automatic send_random_item();
    int          r;
    logic [4:0]  typ;
    logic [2:0]  ndo;
    logic [2:0]  id;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      typ = pick_type();
      ndo = ($urandom_range(0, 1) != 0) ? 3'd0 : 3'($urandom);
      if (typ == TYPE_SOFT_RESET && ndo == 3'd0) begin
        id = 3'd0;
        prev_partner_id = 3'd0;
        partner_id = 3'd1;
      end else if (typ == TYPE_GOODCRC && ndo == 3'd0) begin
        id = 3'($urandom);
      end else if ($urandom_range(0, 99) < 15) begin
        id = prev_partner_id;   // retry of the previous frame
      end else begin
        id = partner_id;
        prev_partner_id = partner_id;
        partner_id = partner_id + 3'd1;
      end
      send_command(CMD_RX_FRAME,
                   pd_header($urandom_range(0, 9) == 0, ndo, id, 1'($urandom), pick_rev(),
                             1'($urandom), typ),
                   SOP_PLAIN);
    end else if (r < 55) begin
      send_command(CMD_RX_FRAME, 16'($urandom), 3'($urandom_range(1, 7)));
    end else if (r < 70) begin
      send_command(CMD_QUEUE_TX, 16'($urandom),
                   ($urandom_range(0, 3) == 0) ? 3'($urandom) : SOP_PLAIN);
    end else if (r < 80) begin
      send_command(CMD_FLUSH_TX, 16'($urandom), 3'($urandom));
    end else if (r < 84) begin
      send_command(CMD_ATTACH, 16'($urandom), 3'($urandom));
    end else if (r < 87) begin
      send_command(CMD_PROT_RESET, 16'($urandom), 3'($urandom));
      partner_id = 3'd0;
    end else if (r < 89) begin
      send_command(CMD_HARD_RESET, 16'($urandom), 3'($urandom));
      partner_id = 3'd0;
    end else begin
      send_command(3'($urandom_range(0, 7)), 16'($urandom), 3'($urandom));
    end
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    send_command(CMD_RX_FRAME,
                 pd_header(1'b0, 3'd1, 3'd0, 1'b0, REV_RESERVED, 1'b0, 5'h03), SOP_PLAIN);
    send_command(CMD_RX_FRAME,
                 pd_header(1'b0, 3'd1, 3'd0, 1'b0, REV_RESERVED, 1'b0, 5'h03), SOP_PLAIN);
    send_command(CMD_RX_FRAME,
                 pd_header(1'b0, 3'd2, 3'd1, 1'b1, REV_3_0, 1'b1, 5'h1F), SOP_PLAIN);
    send_command(CMD_RX_FRAME,
                 pd_header(1'b1, 3'd7, 3'd2, 1'b0, REV_3_0, 1'b0, 5'h1F), SOP_PLAIN);
    send_command(CMD_RX_FRAME,
                 pd_header(1'b0, 3'd0, 3'd5, 1'b0, REV_3_0, 1'b0, TYPE_GOODCRC),
                 SOP_PLAIN);
    send_command(CMD_RX_FRAME,
                 pd_header(1'b0, 3'd0, 3'd6, 1'b1, REV_1_0, 1'b1, TYPE_GOODCRC), 3'd3);
    send_command(CMD_RX_FRAME,
                 pd_header(1'b0, 3'd2, 3'd3, 1'b0, REV_3_0, 1'b0, TYPE_GOODCRC),
                 SOP_PLAIN);
    send_command(CMD_RX_FRAME, 16'hFFFF, 3'd7);
    send_command(CMD_RX_FRAME, 16'h0000, 3'd7);
    // soft reset forgets the last id, so a repeat of it is delivered, then dropped
    send_command(CMD_RX_FRAME,
                 pd_header(1'b0, 3'd0, 3'd3, 1'b0, REV_3_0, 1'b0, TYPE_SOFT_RESET),
                 SOP_PLAIN);
    send_command(CMD_RX_FRAME,
                 pd_header(1'b0, 3'd1, 3'd3, 1'b0, REV_3_0, 1'b0, 5'h02), SOP_PLAIN);
    send_command(CMD_RX_FRAME, 16'hFFFF, SOP_PLAIN);
    send_command(CMD_RX_FRAME, 16'h0000, SOP_PLAIN);
    send_command(CMD_ATTACH, 16'h0000, SOP_PLAIN);
    send_command(CMD_FLUSH_TX, 16'hFFFF, 3'd7);
    send_command(CMD_QUEUE_TX, 16'hFFFF, 3'd7);
    send_command(CMD_QUEUE_TX, 16'h0000, SOP_PLAIN);
    send_command(CMD_FLUSH_TX, 16'h0000, SOP_PLAIN);
    send_command(CMD_PROT_RESET, 16'hFFFF, 3'd7);
    send_command(CMD_QUEUE_TX, 16'h1234, 3'd2);
    send_command(CMD_HARD_RESET, 16'h0000, SOP_PLAIN);
    send_command(CMD_FLUSH_TX, 16'h0000, SOP_PLAIN);
    send_command(CMD_UNUSED_6, 16'h0000, SOP_PLAIN);
    send_command(CMD_UNUSED_7, 16'hFFFF, 3'd7);
  endtask

  task automatic test_roles();
    logic [1:0] combo;
    for (int k = 1; k <= 4; k++) begin
      combo = 2'(k);
      write_roles(combo[0], combo[1]);
      for (int i = 0; i < 3; i++)
        send_command(CMD_RX_FRAME,
                     pd_header(1'b0, 3'($urandom), 3'(i + 4 * k), 1'($urandom), REV_3_0,
                               1'($urandom), 5'($urandom_range(14, 31))),
                     SOP_PLAIN);
    end
  endtask

  task automatic test_random(input int n_items);
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      send_random_item();
    end
    steady = 1'b0;
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_backpressure();
    drain();
    steady   = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_random_item();
    steady   = 1'b0;
  endtask

  // ---------------------------------------------------------------- receiver
  initial begin
    int stall;
    stall = 0;
    out_ch.ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall > 0 && !steady) begin
        out_ch.ready <= 1'b0;
        stall--;
        @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        stall = steady ? 0 : pick_gap();
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------- checker
  task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display("mismatch in %s: expected %h, got %h", what, want, got);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_beats.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("beat with nothing outstanding: action %0d header %h",
                   out_ch.action, out_ch.out_header);
      end else begin
        want = expected_beats.pop_front();
        if (out_ch.action !== want.action)
          flag("action", 32'(want.action), 32'(out_ch.action));
        if (out_ch.out_header !== want.header)
          flag("header", 32'(want.header), 32'(out_ch.out_header));
        if (out_ch.out_sop_kind !== want.sop_kind)
          flag("sop kind", 32'(want.sop_kind), 32'(out_ch.out_sop_kind));
        if (out_ch.our_spec_rev !== want.rev)
          flag("spec rev", 32'(want.rev), 32'(out_ch.our_spec_rev));
        if (out_ch.delivered_total !== want.total)
          flag("delivered total", want.total, out_ch.delivered_total);
        if (out_ch.last !== want.last)
          flag("last", 32'(want.last), 32'(out_ch.last));
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = REG_DATA_ROLE;
    cfg_wdata        = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.command    = CMD_RX_FRAME;
    in_ch.msg_header = '0;
    in_ch.sop_kind   = SOP_PLAIN;
    n_mismatch       = 0;
    idle_cycles      = 0;
    steady           = 1'b0;
    hold_req         = 1'b0;
    partner_id       = '0;
    prev_partner_id  = '0;
    role_dfp         = 1'b0;
    role_src         = 1'b0;
    slot_hdr         = '0;
    slot_sop         = '0;
    cur_rev          = REV_3_0;
    clear_layer();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_roles();
    write_roles(1'b1, 1'b1);
    test_directed();
    for (int ph = 0; ph < 5; ph++) begin
      write_roles(1'($urandom), 1'($urandom));
      test_random(250);
    end
    test_backpressure();

    drain();
    repeat (20) @(posedge clk);
    if (n_mismatch == 0 && expected_beats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
